@@ hdl/sharpen_3x3_stream_assert.svh @@
// Assertion macros for the sharpening filter checker.
// Each macro builds one concurrent assertion clocked on clk and disabled in reset.
`ifndef SHARPEN_3X3_STREAM_ASSERT_SVH
`define SHARPEN_3X3_STREAM_ASSERT_SVH

// Same-cycle implication.
`define SH3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SH3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/sh3_pkg.sv @@
// Shared types, constants and the per-channel sharpening function.
// Used by the result queue and the top level.
package sh3_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int FW_W = 11;
	localparam int FH_W = 13;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	// Register index, taken from paddr[2].
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam int RES_DEPTH = 4;

	typedef logic [23:0] pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} pix_res_t;

	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic last;
	} nbr_flags_t;

	function automatic logic [7:0] sharpen_chan(input logic [7:0] c, input logic [7:0] u,
		input logic [7:0] d, input logic [7:0] l, input logic [7:0] r);
		logic [10:0]       five;
		logic [9:0]        neg;
		logic signed [11:0] v;
		logic [7:0]        res;
		five = {1'b0, c, 2'b00} + {3'b000, c};
		neg  = {2'b00, u} + {2'b00, d} + {2'b00, l} + {2'b00, r};
		v    = $signed({1'b0, five}) - $signed({2'b00, neg});
		if (v < 0) begin
			res = 8'd0;
		end else if (v > 12'sd255) begin
			res = 8'd255;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

endpackage

@@ hdl/sh3_if.sv @@
// Valid/ready stream interfaces for input pixels and sharpened results.
// Does not depend on sh3_pkg; the widths are written out here.
interface sh3_pix_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, output command, output red_in, output green_in,
		output blue_in, input ready);
	modport sink (input valid, input command, input red_in, input green_in,
		input blue_in, output ready);
endinterface

interface sh3_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       frame_end;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output frame_end, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input frame_end, output ready);
endinterface

@@ hdl/sh3_res_fifo.sv @@
// Small result queue between the filter pipeline and the output channel.
// Depends on sh3_pkg for the result type and depth.
module sh3_res_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sh3_pkg::pix_res_t push_data,
	output logic              valid,
	input  logic              ready,
	output sh3_pkg::pix_res_t data
);

	localparam int AW = $clog2(sh3_pkg::RES_DEPTH);

	sh3_pkg::pix_res_t mem_q [sh3_pkg::RES_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          pop;

	assign valid = (count_q != '0);
	assign data  = mem_q[rd_ptr_q];
	assign pop   = valid && ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

@@ hdl/sharpen_3x3_stream.sv @@
// Streaming 3x3 sharpening filter, RGB, one transfer per cycle sustained while the result queue has room.
// A result passes the stage-1 registers, the window registers and the result queue before it leaves.
// Throughput: one item per cycle while the result queue has room; the line stores are read at
// acceptance and the two-rows-back store is written in the next cycle, with forwarding for one-pixel rows.
// Reset clears counters, window, pipeline and queue; line stores are not cleared.
module sharpen_3x3_stream #(
	parameter int MAX_WIDTH  = sh3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sh3_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	sh3_pix_if.sink     pixels,
	sh3_res_if.source   results
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WEW = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_HEIGHT + 3);
	localparam int NW  = $clog2(sh3_pkg::RES_DEPTH + 1);

	logic [sh3_pkg::FW_W-1:0] frame_width_q;
	logic [sh3_pkg::FH_W-1:0] frame_height_q;
	logic [WEW-1:0] w_eff;
	logic [RW-1:0]  h_eff;
	logic           cfg_wr;

	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;

	logic              take, row_done, res_ok, col_wrap, out_wrap;
	sh3_pkg::nbr_flags_t flags;
	sh3_pkg::pixel_t   pix0;

	logic                v_s1, fwd_s1, res_s1;
	logic [CW-1:0]       col_s1;
	sh3_pkg::pixel_t     pix_s1;
	sh3_pkg::nbr_flags_t flags_s1;
	logic                v_s2;
	sh3_pkg::nbr_flags_t flags_s2;

	sh3_pkg::pixel_t mem_a [MAX_WIDTH];
	sh3_pkg::pixel_t mem_b [MAX_WIDTH];
	sh3_pkg::pixel_t rd_a_q, rd_b_q, prev_up1_q, up2;
	sh3_pkg::pixel_t win_q [9];

	logic [NW-1:0]     cnt_q;
	logic              out_xfer;
	sh3_pkg::pix_res_t res_s2, res_head;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == sh3_pkg::REG_FRAME_HEIGHT) ?
		{{(32-sh3_pkg::FH_W){1'b0}}, frame_height_q} :
		{{(32-sh3_pkg::FW_W){1'b0}}, frame_width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sh3_pkg::FRAME_WIDTH_RST;
			frame_height_q <= sh3_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == sh3_pkg::REG_FRAME_WIDTH) begin
				frame_width_q <= pwdata[sh3_pkg::FW_W-1:0];
			end else begin
				frame_height_q <= pwdata[sh3_pkg::FH_W-1:0];
			end
		end
	end

	// Saturated frame size.
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WEW'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = WEW'(MAX_WIDTH);
		end else begin
			w_eff = WEW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = RW'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			h_eff = RW'(MAX_HEIGHT);
		end else begin
			h_eff = RW'(frame_height_q);
		end
	end

	// Acceptance and position bookkeeping, all decided when the transfer happens.
	assign pixels.ready = (cnt_q < NW'(sh3_pkg::RES_DEPTH));
	assign row_done     = (in_row_q >= h_eff);
	assign take = pixels.valid && pixels.ready &&
		((pixels.command == sh3_pkg::CMD_DRAIN) ? row_done : !row_done);
	assign pix0 = (pixels.command == sh3_pkg::CMD_DRAIN) ? '0 :
		{pixels.red_in, pixels.green_in, pixels.blue_in};

	assign res_ok = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
	assign col_wrap = ((WEW'(in_col_q) + WEW'(1)) >= w_eff);
	assign out_wrap = ((WEW'(out_col_q) + WEW'(1)) >= w_eff);

	always_comb begin
		flags.top    = (out_row_q == '0);
		flags.bottom = ((out_row_q + RW'(1)) >= h_eff);
		flags.left   = (out_col_q == '0);
		flags.right  = out_wrap;
		flags.last   = flags.bottom && out_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_wr || (take && res_ok && flags.last)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			in_col_q <= col_wrap ? '0 : in_col_q + CW'(1);
			if (col_wrap) begin
				in_row_q <= in_row_q + RW'(1);
			end
			if (res_ok) begin
				out_col_q <= out_wrap ? '0 : out_col_q + CW'(1);
				if (out_wrap) begin
					out_row_q <= out_row_q + RW'(1);
				end
			end
		end
	end

	// Line stores: the one-row-back store is read and overwritten at acceptance,
	// the two-rows-back store is written in the next cycle with the data just read.
	always_ff @(posedge clk) begin
		if (take) begin
			rd_a_q          <= mem_a[in_col_q];
			mem_a[in_col_q] <= pix0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rd_b_q <= mem_b[in_col_q];
		end
		if (v_s1) begin
			mem_b[col_s1] <= rd_a_q;
		end
	end

	// With one-pixel rows the next item reads the entry being written this cycle.
	assign up2 = fwd_s1 ? prev_up1_q : rd_b_q;

	always_ff @(posedge clk) begin
		if (take) begin
			col_s1   <= in_col_q;
			pix_s1   <= pix0;
			flags_s1 <= flags;
			res_s1   <= res_ok;
			fwd_s1   <= v_s1 && (col_s1 == in_col_q);
		end
		if (v_s1) begin
			prev_up1_q <= rd_a_q;
			flags_s2   <= flags_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1 && res_s1;
			if (v_s1) begin
				for (int k = 0; k < 6; k++) begin
					win_q[k] <= win_q[k+3];
				end
				win_q[6] <= up2;
				win_q[7] <= rd_a_q;
				win_q[8] <= pix_s1;
			end
		end
	end

	// Output stage: neighbours outside the frame take the centre pixel.
	always_comb begin
		sh3_pkg::pixel_t c, u, d, l, r;
		c = win_q[4];
		u = flags_s2.top    ? c : win_q[3];
		d = flags_s2.bottom ? c : win_q[5];
		l = flags_s2.left   ? c : win_q[1];
		r = flags_s2.right  ? c : win_q[7];
		res_s2.red       = sh3_pkg::sharpen_chan(c[23:16], u[23:16], d[23:16], l[23:16],
			r[23:16]);
		res_s2.green     = sh3_pkg::sharpen_chan(c[15:8], u[15:8], d[15:8], l[15:8], r[15:8]);
		res_s2.blue      = sh3_pkg::sharpen_chan(c[7:0], u[7:0], d[7:0], l[7:0], r[7:0]);
		res_s2.frame_end = flags_s2.last;
	end

	// Results in flight plus those queued never exceed the queue depth.
	assign out_xfer = results.valid && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if ((take && res_ok) && !out_xfer) begin
			cnt_q <= cnt_q + NW'(1);
		end else if (!(take && res_ok) && out_xfer) begin
			cnt_q <= cnt_q - NW'(1);
		end
	end

	sh3_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.push_data (res_s2),
		.valid     (results.valid),
		.ready     (results.ready),
		.data      (res_head)
	);

	assign results.red_out   = res_head.red;
	assign results.green_out = res_head.green;
	assign results.blue_out  = res_head.blue;
	assign results.frame_end = res_head.frame_end;

endmodule

@@ hdl/sh3_checker.sv @@
// Port-level checker for the sharpening filter, bound to the top level.
// Depends on sharpen_3x3_stream_assert.svh for the assertion macros.
`include "sharpen_3x3_stream_assert.svh"

module sh3_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pready,
	input logic       pix_valid,
	input logic       pix_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic       frame_end
);

	logic        res_stall;
	logic        pix_xfer;
	logic [24:0] res_bus;

	assign res_stall = res_valid && !res_ready;
	assign pix_xfer  = pix_valid && pix_ready;
	assign res_bus   = {red_out, green_out, blue_out, frame_end};

	`SH3_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")
	`SH3_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res_bus), "stalled result changed")
	// An empty queue only fills from an earlier input transfer.
	`SH3_ASSERT_NOW(a_res_latency, $rose(res_valid), $past(pix_xfer, 3), "result without input")

endmodule

bind sharpen_3x3_stream sh3_checker u_sh3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.pix_valid (pixels.valid),
	.pix_ready (pixels.ready),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.red_out   (results.red_out),
	.green_out (results.green_out),
	.blue_out  (results.blue_out),
	.frame_end (results.frame_end)
);
